// File: hw/rtl/tcv_pkg.sv
// Shared constants for the triclinic cell vector pipeline.
package tcv_pkg;

    // Folded angle argument, 0..9000 hundredths of a degree
    localparam int ARG_W = 14;
    // Unsigned Q30 magnitude, up to and including 1.0
    localparam int Q_W = 31;

    localparam logic [Q_W-1:0] Q30_ONE = 31'h4000_0000;

    // Angle limits in hundredths of a degree
    localparam logic [14:0] RIGHT_ANGLE    = 15'd9000;
    localparam logic [14:0] STRAIGHT_ANGLE = 15'd18000;

    // Register stages through the sine unit
    localparam int LAT_SIN = 26;

endpackage

// File: hw/rtl/tcv_delay.sv
// Enabled shift line that carries a valid bit and a payload word.
module tcv_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_vld,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] data_reg [0:DEPTH-1];
    logic [DEPTH-1:0] vld_reg;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_tap
            if (g == 0) begin : g_first
                // Take the incoming beat
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        vld_reg[g] <= 1'b0;
                    end
                    else if (en)
                    begin
                        vld_reg[g] <= in_vld;
                    end
                end

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        data_reg[g] <= in_data;
                    end
                end
            end
            else begin : g_next
                // Advance one tap
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        vld_reg[g] <= 1'b0;
                    end
                    else if (en)
                    begin
                        vld_reg[g] <= vld_reg[g-1];
                    end
                end

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        data_reg[g] <= data_reg[g-1];
                    end
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[DEPTH-1];
    assign out_data = data_reg[DEPTH-1];

endmodule

// File: hw/rtl/tcv_sin.sv
// Pipelined Q30 sine of a first-quadrant angle, Horner form of the series.
module tcv_sin (
    input  logic                      clk,
    input  logic                      en,
    input  logic [tcv_pkg::ARG_W-1:0] ang,
    output logic [tcv_pkg::Q_W-1:0]   sin_q30
);
    import tcv_pkg::*;

    // pi in Q30, split as pi = 18000 * X_QUO + X_REM
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam logic [17:0] X_QUO = 18'(PI_Q30 / 64'd18000);
    localparam logic [12:0] X_REM = 13'(PI_Q30 % 64'd18000);
    localparam logic [17:0] X_RCP = 18'((64'd1 << 32) / 64'd18000);

    logic [30:0] a1_p_reg;
    logic [25:0] a1_v_reg;
    logic [30:0] a2_p_reg;
    logic [25:0] a2_v_reg;
    logic [11:0] a2_q_reg;
    logic [25:0] a3_rem;
    logic [30:0] a3_x_reg;
    logic [30:0] a4_x_reg;
    logic [31:0] a4_x2_reg;

    logic [30:0] hx_reg  [0:20];
    logic [31:0] hx2_reg [0:20];
    logic [31:0] hp_reg  [0:6];
    logic [31:0] hp2_reg [0:6];
    logic [29:0] hq_reg  [0:6];
    logic [30:0] ht_reg  [0:6];

    logic [31:0] fin_s;

    // Radians: ang * pi / 18000, rounded, without a divider
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_p_reg <= 31'(ang) * 31'(X_QUO);
            a1_v_reg <= 26'(ang) * 26'(X_REM) + 26'd9000;
            a2_p_reg <= a1_p_reg;
            a2_v_reg <= a1_v_reg;
            a2_q_reg <= 12'((44'(a1_v_reg) * 44'(X_RCP)) >> 32);
            a3_x_reg <= a2_p_reg + 31'(a2_q_reg) + 31'(a3_rem >= 26'd18000);
            a4_x_reg <= a3_x_reg;
            a4_x2_reg <= 32'((62'(a3_x_reg) * 62'(a3_x_reg)) >> 30);
        end
    end

    assign a3_rem = a2_v_reg - 26'(a2_q_reg) * 26'd18000;

    genvar i;
    generate
        for (i = 0; i < 7; i++) begin : g_step
            localparam int unsigned KC = (14 - 2 * i) * (15 - 2 * i);
            localparam logic [29:0] RCP = 30'((64'd1 << 32) / 64'(KC));

            logic [30:0] x_in;
            logic [31:0] x2_in;
            logic [30:0] t_in;
            logic [31:0] rem;
            logic [29:0] q;

            if (i == 0) begin : g_head
                assign x_in  = a4_x_reg;
                assign x2_in = a4_x2_reg;
                assign t_in  = Q30_ONE;
            end
            else begin : g_body
                assign x_in  = hx_reg[3*i-1];
                assign x2_in = hx2_reg[3*i-1];
                assign t_in  = ht_reg[i-1];
            end

            assign rem = hp2_reg[i] - 32'(hq_reg[i]) * 32'(KC);
            assign q   = hq_reg[i] + 30'(rem >= 32'(KC));

            // Multiply, divide by the series constant, correct and subtract
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    hp_reg[i]      <= 32'((63'(x2_in) * 63'(t_in)) >> 30);
                    hx_reg[3*i]    <= x_in;
                    hx2_reg[3*i]   <= x2_in;
                    hq_reg[i]      <= 30'((62'(hp_reg[i]) * 62'(RCP)) >> 32);
                    hp2_reg[i]     <= hp_reg[i];
                    hx_reg[3*i+1]  <= hx_reg[3*i];
                    hx2_reg[3*i+1] <= hx2_reg[3*i];
                    ht_reg[i]      <= Q30_ONE - 31'(q);
                    hx_reg[3*i+2]  <= hx_reg[3*i+1];
                    hx2_reg[3*i+2] <= hx2_reg[3*i+1];
                end
            end
        end
    endgenerate

    // Final product with x, capped at one
    assign fin_s = 32'((62'(hx_reg[20]) * 62'(ht_reg[6])) >> 30);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_q30 <= (fin_s > 32'(Q30_ONE)) ? Q30_ONE : fin_s[30:0];
        end
    end

endmodule

// File: hw/rtl/triclinic_cell_vectors.sv
// Top level: triclinic cell parameters to Cartesian cell vectors.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+---------------------------------
//  s_axis   | in        | s_axis_tvalid/tready    | tdata: lengths a b c, angles
//  m_axis   | out       | m_axis_tvalid/tready    | tdata: vectors, tuser: cell_valid
//
// One beat is taken in every cycle in which m_axis is not stalled; the depth of
// the pipeline is set by the sine units, the quotient stages of the
// cy divider and the stages of the cz square root, one bit per stage.
// Reset clears only the valid bits of the stages.
// A stall on m_axis holds every stage at once, so nothing is lost or repeated.
module triclinic_cell_vectors (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // len_a[15:0], len_b[31:16], len_c[47:32], angle_alpha[62:48],
    // angle_beta[77:63], angle_gamma[92:78], zero fill [95:93]
    input  logic [95:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // vec_a_x[15:0], vec_b_x[32:16], vec_b_y[49:33], vec_c_x[66:50],
    // vec_c_y[83:67], vec_c_z[99:84], zero fill [103:100]
    output logic [103:0] m_axis_tdata,
    // cell_valid[0]
    output logic [0:0]   m_axis_tuser
);
    import tcv_pkg::*;

    typedef struct packed {
        logic [15:0] la;
        logic [15:0] lb;
        logic [15:0] lc;
        logic        cg_neg;
        logic        cb_neg;
        logic        ca_neg;
    } in_side_t;

    typedef struct packed {
        logic [15:0] la;
        logic [15:0] lc;
        logic [30:0] m;
        logic        m_neg;
        logic [15:0] bx;
        logic        bx_neg;
        logic [15:0] by;
        logic [15:0] cx;
        logic        cx_neg;
        logic [60:0] cb2;
        logic        sg_zero;
        logic [30:0] sg;
        logic [30:0] ca;
        logic        ca_neg;
    } e1_t;

    typedef struct packed {
        logic [15:0]        la;
        logic [15:0]        lc;
        logic [15:0]        bx;
        logic               bx_neg;
        logic [15:0]        by;
        logic [15:0]        cx;
        logic               cx_neg;
        logic signed [32:0] num;
        logic [60:0]        d;
        logic               sg_zero;
        logic [30:0]        sg;
    } e2_t;

    typedef struct packed {
        logic [15:0] la;
        logic [15:0] bx;
        logic        bx_neg;
        logic [15:0] by;
        logic [15:0] cx;
        logic        cx_neg;
        logic [60:0] d;
        logic        num_neg;
        logic [15:0] lc;
        logic        bad;
    } div_side_t;

    typedef struct packed {
        logic [15:0] la;
        logic [15:0] bx;
        logic        bx_neg;
        logic [15:0] by;
        logic [15:0] cx;
        logic        cx_neg;
        logic [60:0] d;
        logic [60:0] r2;
        logic [15:0] cy;
        logic        cy_neg;
        logic [15:0] lc;
        logic        bad;
    } f1_t;

    typedef struct packed {
        logic [15:0] la;
        logic [15:0] bx;
        logic        bx_neg;
        logic [15:0] by;
        logic [15:0] cx;
        logic        cx_neg;
        logic [15:0] cy;
        logic        cy_neg;
        logic [15:0] lc;
        logic        bad;
    } sq_side_t;

    // Q8.8 length times Q30 fraction, rounded half up, saturated
    function automatic logic [15:0] scale_mag(input logic [15:0] len,
                                              input logic [30:0] frac);
        logic [47:0] prod;
        logic [17:0] rnd;
        prod = 48'(len) * 48'(frac) + 48'h0000_2000_0000;
        rnd  = prod[47:30];
        return (rnd > 18'h0FFFF) ? 16'hFFFF : rnd[15:0];
    endfunction

    function automatic logic [14:0] clamp_ang(input logic [14:0] v);
        return (v > STRAIGHT_ANGLE) ? STRAIGHT_ANGLE : v;
    endfunction

    function automatic logic [ARG_W-1:0] cos_arg(input logic [14:0] v);
        return (v <= RIGHT_ANGLE) ? ARG_W'(RIGHT_ANGLE - v) : ARG_W'(v - RIGHT_ANGLE);
    endfunction

    function automatic logic [16:0] pack17(input logic neg, input logic [15:0] m);
        return neg ? 17'(-{1'b0, m}) : {1'b0, m};
    endfunction

    logic en;

    logic [14:0] ang_al;
    logic [14:0] ang_be;
    logic [14:0] ang_ga;

    logic             t1_vld_reg;
    in_side_t         t1_side_next;
    in_side_t         t1_side_reg;
    logic [ARG_W-1:0] t1_sg_arg_reg;
    logic [ARG_W-1:0] t1_cg_arg_reg;
    logic [ARG_W-1:0] t1_cb_arg_reg;
    logic [ARG_W-1:0] t1_ca_arg_reg;

    logic [Q_W-1:0] sg_q;
    logic [Q_W-1:0] cg_q;
    logic [Q_W-1:0] cb_q;
    logic [Q_W-1:0] ca_q;
    logic           d1_vld;
    in_side_t       d1_side;

    logic e1_vld_reg;
    e1_t  e1_next;
    e1_t  e1_reg;

    logic               e2_vld_reg;
    e2_t                e2_next;
    e2_t                e2_reg;
    logic signed [32:0] ca_s;
    logic signed [32:0] m_s;

    logic        e3_vld_reg;
    div_side_t   e3_side_next;
    div_side_t   e3_side_reg;
    logic [31:0] unum;
    logic [30:0] e3_rem_reg;
    logic [30:0] e3_nlo_reg;
    logic [30:0] e3_den_reg;

    logic [30:0] dv_rem_reg [0:30];
    logic [30:0] dv_nlo_reg [0:30];
    logic [30:0] dv_den_reg [0:30];
    logic [30:0] dv_q_reg   [0:30];
    logic        dv_vld;
    div_side_t   dv_side;

    logic        f1_vld_reg;
    f1_t         f1_next;
    f1_t         f1_reg;
    logic [30:0] r_cap;

    logic        f2_vld_reg;
    sq_side_t    f2_side_next;
    sq_side_t    f2_side_reg;
    logic [61:0] w_diff;
    logic [60:0] f2_v_reg;

    logic [60:0] sq_v_reg [0:30];
    logic [61:0] sq_r_reg [0:30];
    logic        sq_vld;
    sq_side_t    sq_side;

    logic        g1_vld_reg;
    sq_side_t    g1_side_reg;
    logic [15:0] g1_cz_reg;

    logic         o_vld_reg;
    logic [103:0] o_data_next;
    logic [103:0] o_data_reg;
    logic         o_user_reg;

    // Whole pipeline advances whenever the output stage can move
    assign en            = !o_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    // Clamp and fold the angles into the first quadrant
    always_comb
    begin
        ang_al = clamp_ang(s_axis_tdata[62:48]);
        ang_be = clamp_ang(s_axis_tdata[77:63]);
        ang_ga = clamp_ang(s_axis_tdata[92:78]);
        t1_side_next.la     = s_axis_tdata[15:0];
        t1_side_next.lb     = s_axis_tdata[31:16];
        t1_side_next.lc     = s_axis_tdata[47:32];
        t1_side_next.cg_neg = ang_ga > RIGHT_ANGLE;
        t1_side_next.cb_neg = ang_be > RIGHT_ANGLE;
        t1_side_next.ca_neg = ang_al > RIGHT_ANGLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_vld_reg <= 1'b0;
            e1_vld_reg <= 1'b0;
            e2_vld_reg <= 1'b0;
            e3_vld_reg <= 1'b0;
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            g1_vld_reg <= 1'b0;
            o_vld_reg  <= 1'b0;
        end
        else if (en)
        begin
            t1_vld_reg <= s_axis_tvalid;
            e1_vld_reg <= d1_vld;
            e2_vld_reg <= e1_vld_reg;
            e3_vld_reg <= e2_vld_reg;
            f1_vld_reg <= dv_vld;
            f2_vld_reg <= f1_vld_reg;
            g1_vld_reg <= sq_vld;
            o_vld_reg  <= g1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_side_reg   <= t1_side_next;
            t1_sg_arg_reg <= (ang_ga > RIGHT_ANGLE) ? ARG_W'(STRAIGHT_ANGLE - ang_ga)
                                                    : ARG_W'(ang_ga);
            t1_cg_arg_reg <= cos_arg(ang_ga);
            t1_cb_arg_reg <= cos_arg(ang_be);
            t1_ca_arg_reg <= cos_arg(ang_al);
        end
    end

    // Four sine units: sin gamma and the three cosines
    tcv_sin u_sin_sg (.clk(clk), .en(en), .ang(t1_sg_arg_reg), .sin_q30(sg_q));
    tcv_sin u_sin_cg (.clk(clk), .en(en), .ang(t1_cg_arg_reg), .sin_q30(cg_q));
    tcv_sin u_sin_cb (.clk(clk), .en(en), .ang(t1_cb_arg_reg), .sin_q30(cb_q));
    tcv_sin u_sin_ca (.clk(clk), .en(en), .ang(t1_ca_arg_reg), .sin_q30(ca_q));

    tcv_delay #(
        .WIDTH($bits(in_side_t)),
        .DEPTH(LAT_SIN)
    ) u_dly_sin (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_vld(t1_vld_reg), .in_data(t1_side_reg),
        .out_vld(d1_vld), .out_data(d1_side)
    );

    // Products of the trigonometric terms with each other and the lengths
    always_comb
    begin
        e1_next.la      = d1_side.la;
        e1_next.lc      = d1_side.lc;
        e1_next.m       = 31'((62'(cb_q) * 62'(cg_q) + 62'h2000_0000) >> 30);
        e1_next.m_neg   = d1_side.cb_neg ^ d1_side.cg_neg;
        e1_next.bx      = scale_mag(d1_side.lb, cg_q);
        e1_next.bx_neg  = d1_side.cg_neg;
        e1_next.by      = scale_mag(d1_side.lb, sg_q);
        e1_next.cx      = scale_mag(d1_side.lc, cb_q);
        e1_next.cx_neg  = d1_side.cb_neg;
        e1_next.cb2     = 61'(62'(cb_q) * 62'(cb_q));
        e1_next.sg_zero = (sg_q == '0);
        e1_next.sg      = sg_q;
        e1_next.ca      = ca_q;
        e1_next.ca_neg  = d1_side.ca_neg;
    end

    // Numerator of cy and the cos beta part of cz squared
    always_comb
    begin
        ca_s = $signed({2'b00, e1_reg.ca});
        m_s  = $signed({2'b00, e1_reg.m});
        if (e1_reg.ca_neg)
        begin
            ca_s = -ca_s;
        end
        if (e1_reg.m_neg)
        begin
            m_s = -m_s;
        end
        e2_next.la      = e1_reg.la;
        e2_next.lc      = e1_reg.lc;
        e2_next.bx      = e1_reg.bx;
        e2_next.bx_neg  = e1_reg.bx_neg;
        e2_next.by      = e1_reg.by;
        e2_next.cx      = e1_reg.cx;
        e2_next.cx_neg  = e1_reg.cx_neg;
        e2_next.num     = ca_s - m_s;
        e2_next.d       = 61'(62'h1000_0000_0000_0000 - 62'(e1_reg.cb2));
        e2_next.sg_zero = e1_reg.sg_zero;
        e2_next.sg      = e1_reg.sg;
    end

    // Magnitude of the numerator, and the check against sin gamma
    always_comb
    begin
        unum = e2_reg.num[32] ? 32'(-e2_reg.num) : 32'(e2_reg.num);
        e3_side_next.la      = e2_reg.la;
        e3_side_next.bx      = e2_reg.bx;
        e3_side_next.bx_neg  = e2_reg.bx_neg;
        e3_side_next.by      = e2_reg.by;
        e3_side_next.cx      = e2_reg.cx;
        e3_side_next.cx_neg  = e2_reg.cx_neg;
        e3_side_next.d       = e2_reg.d;
        e3_side_next.num_neg = e2_reg.num[32];
        e3_side_next.lc      = e2_reg.lc;
        e3_side_next.bad     = e2_reg.sg_zero || (unum > {1'b0, e2_reg.sg});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg      <= e1_next;
            e2_reg      <= e2_next;
            e3_side_reg <= e3_side_next;
            // Dividend is unum * 2^30 + sg / 2: the halves never overlap
            e3_rem_reg  <= {1'b0, unum[30:1]};
            e3_nlo_reg  <= {unum[0], e2_reg.sg[30:1]};
            e3_den_reg  <= e2_reg.sg;
        end
    end

    // Restoring divider for r, one quotient bit per stage
    genvar j;
    generate
        for (j = 0; j < 31; j++) begin : g_div
            logic [30:0] rem_in;
            logic [30:0] nlo_in;
            logic [30:0] den_in;
            logic [30:0] q_in;
            logic [31:0] shifted;
            logic        ge;

            if (j == 0) begin : g_head
                assign rem_in = e3_rem_reg;
                assign nlo_in = e3_nlo_reg;
                assign den_in = e3_den_reg;
                assign q_in   = '0;
            end
            else begin : g_body
                assign rem_in = dv_rem_reg[j-1];
                assign nlo_in = dv_nlo_reg[j-1];
                assign den_in = dv_den_reg[j-1];
                assign q_in   = dv_q_reg[j-1];
            end

            assign shifted = {rem_in, nlo_in[30-j]};
            assign ge      = shifted >= {1'b0, den_in};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_rem_reg[j] <= ge ? 31'(shifted - {1'b0, den_in}) : shifted[30:0];
                    dv_nlo_reg[j] <= nlo_in;
                    dv_den_reg[j] <= den_in;
                    dv_q_reg[j]   <= {q_in[29:0], ge};
                end
            end
        end
    endgenerate

    tcv_delay #(
        .WIDTH($bits(div_side_t)),
        .DEPTH(31)
    ) u_dly_div (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_vld(e3_vld_reg), .in_data(e3_side_reg),
        .out_vld(dv_vld), .out_data(dv_side)
    );

    // Cap r, square it, scale c by it
    always_comb
    begin
        r_cap = (dv_q_reg[30] > Q30_ONE) ? Q30_ONE : dv_q_reg[30];
        f1_next.la     = dv_side.la;
        f1_next.bx     = dv_side.bx;
        f1_next.bx_neg = dv_side.bx_neg;
        f1_next.by     = dv_side.by;
        f1_next.cx     = dv_side.cx;
        f1_next.cx_neg = dv_side.cx_neg;
        f1_next.d      = dv_side.d;
        f1_next.r2     = 61'(62'(r_cap) * 62'(r_cap));
        f1_next.cy     = scale_mag(dv_side.lc, r_cap);
        f1_next.cy_neg = dv_side.num_neg;
        f1_next.lc     = dv_side.lc;
        f1_next.bad    = dv_side.bad;
    end

    // Radicand of cz; a negative one marks an impossible cell
    always_comb
    begin
        w_diff = {1'b0, f1_reg.d} - {1'b0, f1_reg.r2};
        f2_side_next.la     = f1_reg.la;
        f2_side_next.bx     = f1_reg.bx;
        f2_side_next.bx_neg = f1_reg.bx_neg;
        f2_side_next.by     = f1_reg.by;
        f2_side_next.cx     = f1_reg.cx;
        f2_side_next.cx_neg = f1_reg.cx_neg;
        f2_side_next.cy     = f1_reg.cy;
        f2_side_next.cy_neg = f1_reg.cy_neg;
        f2_side_next.lc     = f1_reg.lc;
        f2_side_next.bad    = f1_reg.bad || w_diff[61];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_reg      <= f1_next;
            f2_side_reg <= f2_side_next;
            f2_v_reg    <= w_diff[60:0];
        end
    end

    // Integer square root, one result bit per stage
    genvar k;
    generate
        for (k = 0; k < 31; k++) begin : g_sqrt
            localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);

            logic [60:0] v_in;
            logic [61:0] r_in;
            logic [61:0] sum;
            logic        ge;

            if (k == 0) begin : g_head
                assign v_in = f2_v_reg;
                assign r_in = '0;
            end
            else begin : g_body
                assign v_in = sq_v_reg[k-1];
                assign r_in = sq_r_reg[k-1];
            end

            assign sum = r_in + BIT;
            assign ge  = 62'(v_in) >= sum;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_v_reg[k] <= ge ? 61'(62'(v_in) - sum) : v_in;
                    sq_r_reg[k] <= ge ? (r_in >> 1) + BIT : r_in >> 1;
                end
            end
        end
    endgenerate

    tcv_delay #(
        .WIDTH($bits(sq_side_t)),
        .DEPTH(31)
    ) u_dly_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_vld(f2_vld_reg), .in_data(f2_side_reg),
        .out_vld(sq_vld), .out_data(sq_side)
    );

    // Scale c by the root, then assemble the output beat
    always_comb
    begin
        if (g1_side_reg.bad)
        begin
            o_data_next = '0;
        end
        else
        begin
            o_data_next = {4'b0000,
                           g1_cz_reg,
                           pack17(g1_side_reg.cy_neg, g1_side_reg.cy),
                           pack17(g1_side_reg.cx_neg, g1_side_reg.cx),
                           pack17(1'b0, g1_side_reg.by),
                           pack17(g1_side_reg.bx_neg, g1_side_reg.bx),
                           g1_side_reg.la};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g1_side_reg <= sq_side;
            g1_cz_reg   <= scale_mag(sq_side.lc, sq_r_reg[30][30:0]);
            o_data_reg  <= o_data_next;
            o_user_reg  <= !g1_side_reg.bad;
        end
    end

    assign m_axis_tvalid   = o_vld_reg;
    assign m_axis_tdata    = o_data_reg;
    assign m_axis_tuser[0] = o_user_reg;

    // Dividend high part stays below the divisor for a possible cell
    a_div_pre: assert property (@(posedge clk) disable iff (!rst_n)
        (e3_vld_reg && !e3_side_reg.bad) |-> (e3_rem_reg < e3_den_reg))
        else $error("divider entered with remainder not below divisor");

    // r never exceeds one for a possible cell
    a_div_out: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_vld && !dv_side.bad) |-> (dv_q_reg[30] <= Q30_ONE))
        else $error("quotient above one");

    // Root of a radicand up to 2^60 is at most 2^30
    a_sqrt_out: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_vld && !sq_side.bad) |-> (sq_r_reg[30] <= 62'(Q30_ONE)))
        else $error("square root above one");

    // An impossible cell leaves every vector at zero
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("invalid cell with nonzero vectors");

endmodule
